// ===== src/packed_bit_field_extractor_core_defines.svh =====
// ---------------------------------------------------------------------------
// Packed bit field extractor assertion macros
// Shared concurrent assertion forms for the extractor's checker.
// ---------------------------------------------------------------------------
`ifndef PACKED_BIT_FIELD_EXTRACTOR_CORE_DEFINES_SVH
`define PACKED_BIT_FIELD_EXTRACTOR_CORE_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define PBFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked on every edge, reset included.
`define PBFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pbfe_pkg.sv =====
// ---------------------------------------------------------------------------
// Packed bit field extractor package
// Request codes, sizes and the queue entry shared by the front and back ends.
// ---------------------------------------------------------------------------
package pbfe_pkg;

  // Default storage sizes.
  localparam int RECORD_BYTES_DEF   = 64;
  localparam int ESCAPE_ENTRIES_DEF = 256;

  // Fixed field widths.
  localparam int REQ_W      = 2;
  localparam int BYTE_ADDR_W = 6;
  localparam int TIDX_IN_W  = 8;
  localparam int OFFSET_W   = 9;
  localparam int LEN_W      = 6;
  localparam int WORD_W     = 32;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_LOAD_BYTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_TABLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXTRACT    = 2'd2;

  // Longest field; longer requests saturate to this.
  localparam logic [LEN_W-1:0] FIELD_MAX_LEN = 6'd32;

  // Record buffer is split into byte banks so a whole window reads at once.
  localparam int NUM_BANKS    = 8;
  localparam int BSEL_W       = $clog2(NUM_BANKS);
  localparam int WINDOW_BYTES = 5;
  localparam int WIN_W        = 8 * WINDOW_BYTES;
  localparam int BASE_W       = OFFSET_W - BSEL_W;
  localparam int POS_W        = BASE_W + 1;

  // Queue between front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD_BYTE  = 2'd0,
    OP_LOAD_TABLE = 2'd1,
    OP_EXTRACT    = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [BYTE_ADDR_W-1:0] byte_addr;
    logic [7:0]            byte_data;
    logic [TIDX_IN_W-1:0]  table_index;
    logic [WORD_W-1:0]     table_value;
    logic [OFFSET_W-1:0]   bit_offset;
    logic [LEN_W-1:0]      field_len;
    logic [WORD_W-1:0]     escape_max;
    logic                  use_escape;
  } entry_t;

endpackage

// ===== src/pbfe_front.sv =====
// ---------------------------------------------------------------------------
// Packed bit field extractor front end
// Accepts requests, drops those with no effect and queues the rest.
// ---------------------------------------------------------------------------
module pbfe_front #(
  parameter int RECORD_BYTES   = pbfe_pkg::RECORD_BYTES_DEF,
  parameter int ESCAPE_ENTRIES = pbfe_pkg::ESCAPE_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [pbfe_pkg::REQ_W-1:0]            in_req_type,
  input  logic [pbfe_pkg::BYTE_ADDR_W-1:0]      in_byte_addr,
  input  logic [7:0]                            in_byte_data,
  input  logic [pbfe_pkg::TIDX_IN_W-1:0]        in_table_index,
  input  logic signed [pbfe_pkg::WORD_W-1:0]    in_table_value,
  input  logic [pbfe_pkg::OFFSET_W-1:0]         in_bit_offset,
  input  logic [pbfe_pkg::LEN_W-1:0]            in_field_length,
  input  logic signed [pbfe_pkg::WORD_W-1:0]    in_escape_max,
  input  logic                                  in_use_escape,
  output logic                                  q_valid,
  output pbfe_pkg::entry_t                      q_entry,
  input  logic                                  q_pop
);

  pbfe_pkg::entry_t                 q_mem [pbfe_pkg::QUEUE_DEPTH];
  logic [pbfe_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [pbfe_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [pbfe_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             keep;
  logic                             push;
  pbfe_pkg::op_t                    kind;
  pbfe_pkg::entry_t                 new_entry;

  // Classify the request; out-of-range loads and the unused code are dropped.
  always_comb begin
    keep = 1'b0;
    kind = pbfe_pkg::OP_EXTRACT;
    unique case (in_req_type)
      pbfe_pkg::REQ_LOAD_BYTE: begin
        kind = pbfe_pkg::OP_LOAD_BYTE;
        keep = int'(in_byte_addr) < RECORD_BYTES;
      end
      pbfe_pkg::REQ_LOAD_TABLE: begin
        kind = pbfe_pkg::OP_LOAD_TABLE;
        keep = int'(in_table_index) < ESCAPE_ENTRIES;
      end
      pbfe_pkg::REQ_EXTRACT: begin
        kind = pbfe_pkg::OP_EXTRACT;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    new_entry.op          = kind;
    new_entry.byte_addr   = in_byte_addr;
    new_entry.byte_data   = in_byte_data;
    new_entry.table_index = in_table_index;
    new_entry.table_value = in_table_value;
    new_entry.bit_offset  = in_bit_offset;
    new_entry.field_len   = (in_field_length > pbfe_pkg::FIELD_MAX_LEN) ?
                            pbfe_pkg::FIELD_MAX_LEN : in_field_length;
    new_entry.escape_max  = in_escape_max;
    new_entry.use_escape  = in_use_escape;
  end

  assign in_ready = cnt_r != pbfe_pkg::QCNT_W'(pbfe_pkg::QUEUE_DEPTH);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = cnt_r != '0;
  assign q_entry  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (q_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_entry;
    end
  end

endmodule

// ===== src/pbfe_back.sv =====
// ---------------------------------------------------------------------------
// Packed bit field extractor back end
// Holds the record banks and escape table, executes queued requests.
// ---------------------------------------------------------------------------
module pbfe_back #(
  parameter int RECORD_BYTES   = pbfe_pkg::RECORD_BYTES_DEF,
  parameter int ESCAPE_ENTRIES = pbfe_pkg::ESCAPE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  pbfe_pkg::entry_t                   q_entry,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pbfe_pkg::WORD_W-1:0] out_field_value,
  output logic                               out_escaped,
  output logic                               out_index_error
);

  localparam int BANK_DEPTH = (RECORD_BYTES + pbfe_pkg::NUM_BANKS - 1) / pbfe_pkg::NUM_BANKS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int ROW_IN_W   = pbfe_pkg::POS_W - pbfe_pkg::BSEL_W;
  localparam int ROW_W      = (BANK_AW > ROW_IN_W) ? BANK_AW : ROW_IN_W;
  localparam int TAB_AW     = (ESCAPE_ENTRIES > 1) ? $clog2(ESCAPE_ENTRIES) : 1;
  localparam int TIDX_W     = (TAB_AW > pbfe_pkg::TIDX_IN_W) ? TAB_AW : pbfe_pkg::TIDX_IN_W;
  localparam int DIFF_W     = pbfe_pkg::WORD_W + 2;
  localparam int BSEL_W     = pbfe_pkg::BSEL_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXT  = 4'b0010,
    ST_ESC  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                              state_r, state_nxt;
  pbfe_pkg::entry_t                    cur_r;
  logic [7:0]                          bank_q_r [pbfe_pkg::NUM_BANKS];
  logic [pbfe_pkg::WINDOW_BYTES-1:0]   inr_r;
  logic [pbfe_pkg::WORD_W-1:0]         raw_r;
  logic                                hit_r;
  logic                                err_r;
  logic [pbfe_pkg::WORD_W-1:0]         tab_q_r;
  logic [pbfe_pkg::WORD_W-1:0]         tab_mem [ESCAPE_ENTRIES];
  logic                                out_valid_r;
  logic [pbfe_pkg::WORD_W-1:0]         out_value_r;
  logic                                out_escaped_r;
  logic                                out_error_r;

  logic                                rd_en;
  logic                                byte_wr;
  logic                                tab_wr;
  logic [pbfe_pkg::BASE_W-1:0]         base;
  logic [TIDX_W-1:0]                   tidx_ext;
  logic [pbfe_pkg::WIN_W-1:0]          window;
  logic [pbfe_pkg::WIN_W-1:0]          aligned;
  logic [pbfe_pkg::WORD_W-1:0]         top_bits;
  logic [pbfe_pkg::LEN_W-1:0]          rshift;
  logic [pbfe_pkg::WORD_W-1:0]         raw;
  logic signed [DIFF_W-1:0]            diff;
  logic                                esc_go;
  logic                                in_tab;
  logic                                out_load;
  logic [pbfe_pkg::WORD_W-1:0]         res_value;

  assign q_pop   = (state_r == ST_IDLE) && q_valid;
  assign rd_en   = q_pop && (q_entry.op == pbfe_pkg::OP_EXTRACT);
  assign byte_wr = q_pop && (q_entry.op == pbfe_pkg::OP_LOAD_BYTE);
  assign tab_wr  = q_pop && (q_entry.op == pbfe_pkg::OP_LOAD_TABLE);
  assign base    = q_entry.bit_offset[pbfe_pkg::OFFSET_W-1:BSEL_W];

  // Each bank holds every eighth byte; all banks read in the same cycle.
  for (genvar b = 0; b < pbfe_pkg::NUM_BANKS; b++) begin : g_bank
    logic [7:0]                   mem [BANK_DEPTH];
    logic [BSEL_W-1:0]            k;
    logic [pbfe_pkg::POS_W-1:0]   pos;
    logic [ROW_W-1:0]             rd_row;
    logic [ROW_W-1:0]             wr_row;

    assign k      = BSEL_W'(b) - base[BSEL_W-1:0];
    assign pos    = pbfe_pkg::POS_W'(base) + pbfe_pkg::POS_W'(k);
    assign rd_row = ROW_W'(pos[pbfe_pkg::POS_W-1:BSEL_W]);
    assign wr_row = ROW_W'(q_entry.byte_addr[pbfe_pkg::BYTE_ADDR_W-1:BSEL_W]);

    always_ff @(posedge clk) begin
      if (byte_wr && (q_entry.byte_addr[BSEL_W-1:0] == BSEL_W'(b))) begin
        mem[wr_row[BANK_AW-1:0]] <= q_entry.byte_data;
      end
      if (rd_en) begin
        bank_q_r[b] <= mem[rd_row[BANK_AW-1:0]];
      end
    end
  end

  // Window bytes past the end of the buffer read as zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_r <= q_entry;
      for (int k = 0; k < pbfe_pkg::WINDOW_BYTES; k++) begin
        inr_r[k] <= (int'(base) + k) < RECORD_BYTES;
      end
    end
  end

  // Assemble the five-byte window and cut the field out of it. Window byte k
  // sits in the bank picked by the low bits of its byte address.
  always_comb begin
    window = '0;
    for (int k = 0; k < pbfe_pkg::WINDOW_BYTES; k++) begin
      window[pbfe_pkg::WIN_W-1-8*k -: 8] =
        inr_r[k] ? bank_q_r[BSEL_W'(int'(cur_r.bit_offset[2*BSEL_W-1:BSEL_W]) + k)] : 8'h00;
    end
    aligned  = window << cur_r.bit_offset[BSEL_W-1:0];
    top_bits = aligned[pbfe_pkg::WIN_W-1 -: pbfe_pkg::WORD_W];
    rshift   = pbfe_pkg::FIELD_MAX_LEN - cur_r.field_len;
    raw      = top_bits >> rshift;
  end

  // Escape index, computed wide enough that it never wraps.
  assign tidx_ext = TIDX_W'(q_entry.table_index);
  assign diff     = DIFF_W'($signed(raw_r)) - DIFF_W'($signed(cur_r.escape_max))
                    - DIFF_W'(1);
  assign esc_go   = cur_r.use_escape && !diff[DIFF_W-1];
  assign in_tab   = diff[DIFF_W-2:0] < (DIFF_W-1)'(ESCAPE_ENTRIES);

  always_ff @(posedge clk) begin
    if (tab_wr) begin
      tab_mem[tidx_ext[TAB_AW-1:0]] <= q_entry.table_value;
    end
    if ((state_r == ST_ESC) && esc_go && in_tab) begin
      tab_q_r <= tab_mem[diff[TAB_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXT) begin
      raw_r <= raw;
    end
    if (state_r == ST_ESC) begin
      hit_r <= esc_go && in_tab;
      err_r <= esc_go && !in_tab;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (rd_en) begin
          state_nxt = ST_EXT;
        end
      end
      ST_EXT: begin
        state_nxt = ST_ESC;
      end
      ST_ESC: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign res_value = hit_r ? tab_q_r : (err_r ? '0 : raw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r   <= res_value;
      out_escaped_r <= hit_r;
      out_error_r   <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_field_value = $signed(out_value_r);
  assign out_escaped     = out_escaped_r;
  assign out_index_error = out_error_r;

endmodule

// ===== src/packed_bit_field_extractor_core.sv =====
// ---------------------------------------------------------------------------
// Packed bit field extractor
// Decodes MSB-first bit fields from a record buffer with an escape table.
// ---------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/ready). A load byte request
// writes one record byte, a load table request writes one escape table
// word, and an extract request produces exactly one result on the out_
// channel; other requests produce nothing. Loads and extracts take effect
// strictly in arrival order.
// A two-entry request queue separates the input handshake from execution,
// so requests are taken while an earlier extract is still being worked on
// or its result waits at the output.
// Execution: a load is written to its store as it leaves the queue. An
// extract goes through these steps in order: the banked record read (all
// eight byte banks at once), aligning and masking the field, the escape
// index and table read, and handing the result to the output register,
// which waits while the receiver still holds an earlier result. The back
// end takes no new request from the queue until an extract has finished.
// Reset empties the queue and drops any pending result; record and table
// contents are not cleared and must be loaded before they are read.
// When the receiver holds out_ready low, the result stays put, the back end
// waits, and the queue fills until in_ready falls.
// ---------------------------------------------------------------------------
module packed_bit_field_extractor_core #(
  parameter int RECORD_BYTES   = pbfe_pkg::RECORD_BYTES_DEF,
  parameter int ESCAPE_ENTRIES = pbfe_pkg::ESCAPE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pbfe_pkg::REQ_W-1:0]         in_req_type,
  input  logic [pbfe_pkg::BYTE_ADDR_W-1:0]   in_byte_addr,
  input  logic [7:0]                         in_byte_data,
  input  logic [pbfe_pkg::TIDX_IN_W-1:0]     in_table_index,
  input  logic signed [pbfe_pkg::WORD_W-1:0] in_table_value,
  input  logic [pbfe_pkg::OFFSET_W-1:0]      in_bit_offset,
  input  logic [pbfe_pkg::LEN_W-1:0]         in_field_length,
  input  logic signed [pbfe_pkg::WORD_W-1:0] in_escape_max,
  input  logic                               in_use_escape,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pbfe_pkg::WORD_W-1:0] out_field_value,
  output logic                               out_escaped,
  output logic                               out_index_error
);

  // Queue head as seen by the back end.
  logic             q_valid;
  logic             q_pop;
  pbfe_pkg::entry_t q_entry;

  // The front end classifies each request and queues those with an effect.
  pbfe_front #(
    .RECORD_BYTES   (RECORD_BYTES),
    .ESCAPE_ENTRIES (ESCAPE_ENTRIES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_byte_addr    (in_byte_addr),
    .in_byte_data    (in_byte_data),
    .in_table_index  (in_table_index),
    .in_table_value  (in_table_value),
    .in_bit_offset   (in_bit_offset),
    .in_field_length (in_field_length),
    .in_escape_max   (in_escape_max),
    .in_use_escape   (in_use_escape),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop)
  );

  // The back end owns both stores and the output register.
  pbfe_back #(
    .RECORD_BYTES   (RECORD_BYTES),
    .ESCAPE_ENTRIES (ESCAPE_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_field_value (out_field_value),
    .out_escaped     (out_escaped),
    .out_index_error (out_index_error)
  );

endmodule

// ===== src/pbfe_checker.sv =====
// ---------------------------------------------------------------------------
// Packed bit field extractor checker
// Port-level properties of the extractor, bound to the top level.
// ---------------------------------------------------------------------------
`include "packed_bit_field_extractor_core_defines.svh"

module pbfe_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [pbfe_pkg::WORD_W-1:0] out_field_value,
  input logic                               out_escaped,
  input logic                               out_index_error
);

  // A result held back by the receiver stays offered.
  `PBFE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result withdrawn while stalled")

  // A stalled result keeps its value.
  `PBFE_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_field_value) && $stable(out_escaped) && $stable(out_index_error), "result changed while stalled")

  // An index outside the table gives a zero word that is not an escape.
  `PBFE_ASSERT(a_err_zero, clk, rst_n, out_valid && out_index_error |-> out_field_value == 0 && !out_escaped, "index error with non-zero or escaped result")

  // Reset drops any pending result.
  `PBFE_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind packed_bit_field_extractor_core pbfe_checker u_pbfe_checker (.*);
